// ===== rtl/core/fspa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fspa_pkg
// Types and constants shared by the slot pool allocator modules.
// ----------------------------------------------------------------------------
package fspa_pkg;

  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned LINK_DEPTH = 1 << SLOT_W;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  typedef struct packed {
    mode_e             mode;
    logic [SLOT_W-1:0] free_slot;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_e           status;
  } out_t;

  // One free-list link: valid marks that a further entry follows
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] next;
  } link_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    link_t             wdata;
  } link_req_t;

  typedef struct packed {
    logic inc;
    logic clr;
  } fresh_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/fspa_link_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fspa_link_ram
// Next-link memory of the free list, one port, registered read data.
// ----------------------------------------------------------------------------
module fspa_link_ram
  import fspa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire link_req_t req_i,
  output link_t          rdata_o
);

  link_t mem [LINK_DEPTH];
  link_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/fspa_fresh_cnt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fspa_fresh_cnt
// Counter of never-used slots handed out, saturating at the pool capacity.
// ----------------------------------------------------------------------------
module fspa_fresh_cnt
  import fspa_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire fresh_ctl_t   ctl_i,
  output logic              avail_o,
  output logic [SLOT_W-1:0] slot_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count_q, count_d;

  assign avail_o = (count_q != CAP);
  assign slot_o  = SLOT_W'(count_q);  // wide slot numbers wrap to the port width

  always_comb begin
    count_d = count_q;
    if (ctl_i.clr) begin
      count_d = '0;
    end else if (ctl_i.inc && avail_o) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fixed_slot_pool_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator
// Fixed-size slot allocator: LIFO free list in a link memory plus a
// fresh-slot counter.
// ----------------------------------------------------------------------------
// One word in gives one word out. An allocate that pops the free list passes
// through ST_POP, since the next link comes from the link memory in the cycle
// after the read is issued; allocate from fresh slots, free, release-all and the
// unused mode load the result straight from ST_IDLE. One word is in flight at a time; the output
// register lets the next word enter in the cycle the result is taken. The link
// memory needs no clearing after reset: a pop only reads an entry its own
// push wrote. Slot numbers beyond 1023 are reported in their low 10 bits.
module fixed_slot_pool_allocator
  import fspa_pkg::*;
#(
  parameter int unsigned SLOTS_PER_BLOCK = 64,
  parameter int unsigned NUM_BLOCKS      = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int unsigned CAPACITY = SLOTS_PER_BLOCK * NUM_BLOCKS;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic              nonempty_q, nonempty_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;
  logic              out_load;
  logic              out_free;
  logic              accept;

  link_req_t         link_req;
  link_t             link_rdata;
  fresh_ctl_t        fresh_ctl;
  logic              fresh_avail;
  logic [SLOT_W-1:0] fresh_slot;

  fspa_link_ram u_link_ram (
    .clk_i  (clk_i),
    .req_i  (link_req),
    .rdata_o(link_rdata)
  );

  fspa_fresh_cnt #(
    .CAPACITY(CAPACITY)
  ) u_fresh_cnt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fresh_ctl),
    .avail_o(fresh_avail),
    .slot_o (fresh_slot)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    nonempty_d    = nonempty_q;
    out_d         = out_q;
    out_load      = 1'b0;
    link_req      = '0;
    fresh_ctl     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d    = '{slot: '0, status: STATUS_OK};
          out_load = 1'b1;
          unique case (in_data_i.mode)
            MODE_ALLOC: begin
              if (nonempty_q) begin
                // pop: fetch the link, finish next cycle
                link_req.re   = 1'b1;
                link_req.addr = head_q;
                out_load      = 1'b0;
                state_d       = ST_POP;
              end else if (fresh_avail) begin
                out_d.slot    = fresh_slot;
                fresh_ctl.inc = 1'b1;
              end else begin
                out_d.status  = STATUS_FULL;
              end
            end
            MODE_FREE: begin
              link_req.we    = 1'b1;
              link_req.addr  = in_data_i.free_slot;
              link_req.wdata = '{valid: nonempty_q, next: head_q};
              head_d         = in_data_i.free_slot;
              nonempty_d     = 1'b1;
              out_d.slot     = in_data_i.free_slot;
            end
            MODE_RELEASE: begin
              head_d        = '0;
              nonempty_d    = 1'b0;
              fresh_ctl.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          out_d      = '{slot: head_q, status: STATUS_OK};
          out_load   = 1'b1;
          head_d     = link_rdata.next;
          nonempty_d = link_rdata.valid;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      nonempty_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/core/fspa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fspa_checker
// Port-level checks for the slot pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fspa_checker
  import fspa_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // single result register: no new word while one waits
  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while result is stalled");

  a_free_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.mode == MODE_FREE |=>
      out_valid_o && out_data_o.slot == $past(in_data_i.free_slot) &&
      out_data_o.status == STATUS_OK)
    else $error("free did not echo its slot");

  a_release_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.mode == MODE_RELEASE |=>
      out_valid_o && out_data_o.slot == '0 && out_data_o.status == STATUS_OK)
    else $error("release-all result wrong");

  a_full_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_FULL |-> out_data_o.slot == '0)
    else $error("failed allocation reports nonzero slot");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the slot pool allocator. Words go in through a
// valid/ready driver; an in-bench copy of the free list and fresh counter
// predicts every result; a checker compares results in order. Covers LIFO
// reuse, fresh hand-out, release-all, the unused mode, and pool exhaustion.
// ----------------------------------------------------------------------------
module testbench;
  import fspa_pkg::*;

  localparam int unsigned SPB        = 64;
  localparam int unsigned NBLK       = 16;
  localparam int unsigned CAPACITY   = SPB * NBLK;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned DRAIN_CYC  = 10;
  localparam mode_e       MODE_UNUSED = mode_e'(2'b11);

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_word;
  logic out_valid;
  logic out_ready;
  out_t out_word;

  fixed_slot_pool_allocator #(
    .SLOTS_PER_BLOCK(SPB),
    .NUM_BLOCKS     (NBLK)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted allocator state
  logic [SLOT_W-1:0] pool_head;
  logic              pool_nonempty;
  int unsigned       fresh_used;
  link_t             link_mem [LINK_DEPTH];

  out_t        expected_results [$];
  int unsigned held_slots [$];
  bit          idle_en;
  int unsigned errors;
  int unsigned n_alloc, n_free, n_release, n_unused, n_full;

  function automatic out_t pool_step(in_t w);
    out_t  r;
    link_t lk;
    r.slot   = '0;
    r.status = STATUS_OK;
    case (w.mode)
      MODE_ALLOC: begin
        if (pool_nonempty) begin
          lk            = link_mem[pool_head];
          r.slot        = pool_head;
          pool_head     = lk.next;
          pool_nonempty = lk.valid;
        end else if (fresh_used < CAPACITY) begin
          r.slot     = fresh_used[SLOT_W-1:0];
          fresh_used = fresh_used + 1;
        end else begin
          r.status = STATUS_FULL;
        end
      end
      MODE_FREE: begin
        link_mem[w.free_slot] = '{valid: pool_nonempty, next: pool_head};
        pool_head     = w.free_slot;
        pool_nonempty = 1'b1;
        r.slot        = w.free_slot;
      end
      MODE_RELEASE: begin
        pool_head     = '0;
        pool_nonempty = 1'b0;
        fresh_used    = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_t make_word(mode_e m, int unsigned s);
    in_t w;
    w.mode      = m;
    w.free_slot = s[SLOT_W-1:0];
    return w;
  endfunction

  // Drive one word, hold it until taken, then predict its result.
  task automatic send_word(in_t w);
    out_t r;
    int   k;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (!in_ready);
    r = pool_step(w);
    expected_results.push_back(r);
    case (w.mode)
      MODE_ALLOC: begin
        n_alloc++;
        if (r.status == STATUS_FULL) n_full++;
        else held_slots.push_back(r.slot);
      end
      MODE_FREE: begin
        n_free++;
        k = -1;
        foreach (held_slots[i]) if (k < 0 && held_slots[i] == w.free_slot) k = i;
        if (k >= 0) held_slots.delete(k);
      end
      MODE_RELEASE: begin
        n_release++;
        held_slots.delete();
      end
      default: n_unused++;
    endcase
  endtask

  // a slot to give back: mostly one in use, sometimes any index at all
  function automatic int unsigned pick_free_slot();
    int unsigned i;
    if (held_slots.size() != 0 && $urandom_range(0, 9) < 7) begin
      i = $urandom_range(0, held_slots.size() - 1);
      return held_slots[i];
    end
    return $urandom_range(0, LINK_DEPTH - 1);
  endfunction

  task automatic send_random(int unsigned count);
    int unsigned sent;
    int unsigned r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 50) send_word(make_word(MODE_ALLOC, $urandom));
      else if (r < 85) send_word(make_word(MODE_FREE, pick_free_slot()));
      else if (r < 95) send_word(make_word(MODE_RELEASE, $urandom));
      else send_word(make_word(MODE_UNUSED, $urandom));
      if (r < 95) sent++;
    end
  endtask

  task automatic test_directed();
    send_word(make_word(MODE_ALLOC, 0));
    send_word(make_word(MODE_ALLOC, 1023));
    send_word(make_word(MODE_ALLOC, 0));
    send_word(make_word(MODE_FREE, 1));
    send_word(make_word(MODE_FREE, 1023));
    send_word(make_word(MODE_ALLOC, 0));      // pops 1023
    send_word(make_word(MODE_ALLOC, 0));      // pops 1, list empty again
    send_word(make_word(MODE_ALLOC, 0));      // fresh 3
    send_word(make_word(MODE_UNUSED, 1023));
    send_word(make_word(MODE_FREE, 0));
    send_word(make_word(MODE_FREE, 'h2AA));
    send_word(make_word(MODE_FREE, 'h155));
    send_word(make_word(MODE_FREE, 'h155));   // double free goes through
    repeat (5) send_word(make_word(MODE_ALLOC, 'h3FF));
    send_word(make_word(MODE_RELEASE, 1023));
    send_word(make_word(MODE_ALLOC, 0));      // counter restarted
    send_word(make_word(MODE_FREE, 0));
    send_word(make_word(MODE_ALLOC, 0));
    send_word(make_word(MODE_RELEASE, 0));
    send_word(make_word(MODE_RELEASE, 0));
    send_word(make_word(MODE_UNUSED, 0));
  endtask

  task automatic test_random_mix();
    send_random(600);
  endtask

  // Drain the fresh slots, then hit the full condition and recover from it.
  task automatic test_exhaustion();
    send_word(make_word(MODE_RELEASE, $urandom));
    while (!(fresh_used == CAPACITY && !pool_nonempty)) begin
      if ($urandom_range(0, 15) == 0) send_word(make_word(MODE_FREE, pick_free_slot()));
      else send_word(make_word(MODE_ALLOC, $urandom));
    end
    repeat (6) send_word(make_word(MODE_ALLOC, $urandom));
    repeat (2) send_word(make_word(MODE_FREE, pick_free_slot()));
    repeat (3) send_word(make_word(MODE_ALLOC, $urandom));
    send_word(make_word(MODE_RELEASE, $urandom));
    send_word(make_word(MODE_ALLOC, $urandom));
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    send_random(400);
  endtask

  // result sink: random stall bursts while idling is on
  initial begin
    int unsigned hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && hold == 0 && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 16);
      out_ready = (hold == 0);
      if (hold != 0) hold--;
    end
  end

  always @(posedge clk) begin
    out_t ex;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: slot %0d status %0d", out_word.slot, out_word.status);
      end else begin
        ex = expected_results.pop_front();
        if (ex.slot !== out_word.slot || ex.status !== out_word.status) begin
          errors++;
          if (errors <= 10)
            $display("word mismatch: slot exp %0d got %0d, status exp %0d got %0d",
                     ex.slot, out_word.slot, ex.status, out_word.status);
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  int unsigned stall_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("fixed_slot_pool_allocator: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    idle_en       = 1'b1;
    errors        = 0;
    n_alloc       = 0;
    n_free        = 0;
    n_release     = 0;
    n_unused      = 0;
    n_full        = 0;
    pool_head     = '0;
    pool_nonempty = 1'b0;
    fresh_used    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_mix();
    test_exhaustion();
    test_steady_stream();

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d words: %0d allocate, %0d free, %0d release-all, %0d unused mode",
             n_alloc + n_free + n_release + n_unused, n_alloc, n_free, n_release, n_unused);
    $display("%0d allocations refused with the pool full", n_full);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("fixed_slot_pool_allocator: match");
    end else begin
      $display("fixed_slot_pool_allocator: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fspa_pkg.sv
rtl/core/fspa_link_ram.sv
rtl/core/fspa_fresh_cnt.sv
rtl/core/fixed_slot_pool_allocator.sv
rtl/core/fspa_checker.sv
tb/sv/testbench.sv
